// ----- rtl/cbep_pkg.sv -----
// Shared types, widths and constants of the capacity balanced entry placer.
`default_nettype none

package cbep_pkg;

  localparam int NODE_COUNT_DEF  = 8;
  localparam int SPILL_DEPTH_DEF = 32;

  localparam int TAG_W     = 16;
  localparam int HOME_W    = 3;
  localparam int BYTES_W   = 32;
  localparam int FILL_W    = 40;
  localparam int REM_W     = FILL_W + 1;
  localparam int CFG_IDX_W = 4;

  localparam logic [FILL_W-1:0] FILL_MAX = {FILL_W{1'b1}};

  typedef struct packed {
    logic [TAG_W-1:0]   entry_tag;
    logic [HOME_W-1:0]  home_node;
    logic [BYTES_W-1:0] entry_bytes;
    logic               last_entry;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  result_tag;
    logic [HOME_W-1:0] dest_node;
    logic              moved;
    logic              second_pass;
    logic              dropped;
    logic              last_result;
  } out_item_t;

  // One overflow buffer entry.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [HOME_W-1:0]  home;
    logic [BYTES_W-1:0] bytes;
  } spill_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT,
    ST_FL_READ,
    ST_FL_SCAN,
    ST_FL_EMIT
  } ctrl_state_t;

  // Which node index drives the fill/target read port.
  typedef enum logic [1:0] {
    FS_HOME,
    FS_SCAN,
    FS_BEST
  } fill_sel_t;

  typedef struct packed {
    logic      ld_item;
    fill_sel_t fill_sel;
    logic      emit_item;
    logic      spill_wr;
    logic      flush_rd;
    logic      scan_step;
    logic      emit_flush;
    logic      round_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic keep;
    logic spill_full;
    logic last_entry;
    logic cnt_zero;
    logic scan_done;
    logic flush_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/cbep_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cbep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/cbep_datapath.sv -----
// Datapath: targets, node fills, overflow buffer, node scan and result register.
`default_nettype none

module cbep_datapath
  import cbep_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int SPILL_DEPTH = SPILL_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire in_item_t             in_data,
  output out_item_t                 out_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FILL_W-1:0]    cfg_data,
  input  wire ctrl_cmd_t            cmd,
  output ctrl_sts_t                 sts
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int ADDR_W = (SPILL_DEPTH > 1) ? $clog2(SPILL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SPILL_DEPTH + 1);

  logic [FILL_W-1:0]  target_r [NODE_COUNT];
  logic [FILL_W-1:0]  fill_r   [NODE_COUNT];
  in_item_t           item_r;
  logic [CNT_W-1:0]   count_r;
  logic [ADDR_W-1:0]  fi_r;
  logic [NODE_W-1:0]  scan_idx_r;
  logic [NODE_W-1:0]  best_idx_r;
  logic signed [REM_W-1:0] best_rem_r;
  out_item_t          out_data_r;
  logic               out_valid_r;

  logic [NODE_W-1:0]  node_addr;
  logic [FILL_W-1:0]  fill_rd;
  logic [FILL_W-1:0]  tgt_rd;
  logic [FILL_W-1:0]  room;
  logic               home_ok;
  logic [BYTES_W-1:0] add_bytes;
  logic [REM_W-1:0]   sum;
  logic [FILL_W-1:0]  sat_sum;
  logic signed [REM_W-1:0] rem;
  logic               fill_we;
  spill_t             spill_wr_data;
  spill_t             spill_rd;
  logic               out_free;

  // Single read port on the node tables
  always_comb begin
    case (cmd.fill_sel)
      FS_HOME: node_addr = item_r.home_node[NODE_W-1:0];
      FS_SCAN: node_addr = scan_idx_r;
      FS_BEST: node_addr = best_idx_r;
      default: node_addr = item_r.home_node[NODE_W-1:0];
    endcase
  end

  assign fill_rd = fill_r[node_addr];
  assign tgt_rd  = target_r[node_addr];
  assign room    = tgt_rd - fill_rd;
  assign home_ok = 32'(item_r.home_node) < NODE_COUNT;
  assign rem     = $signed({1'b0, tgt_rd}) - $signed({1'b0, fill_rd});

  assign add_bytes = (cmd.fill_sel == FS_BEST) ? spill_rd.bytes : item_r.entry_bytes;
  assign sum       = {1'b0, fill_rd} + REM_W'(add_bytes);
  assign sat_sum   = sum[FILL_W] ? FILL_MAX : sum[FILL_W-1:0];
  assign fill_we   = (cmd.emit_item && sts.keep) || cmd.emit_flush;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts.keep       = home_ok && (fill_rd < tgt_rd) &&
                     ({room, 1'b0} >= REM_W'(item_r.entry_bytes));
    sts.spill_full = count_r == CNT_W'(SPILL_DEPTH);
    sts.last_entry = item_r.last_entry;
    sts.cnt_zero   = count_r == '0;
    sts.scan_done  = scan_idx_r == NODE_W'(NODE_COUNT - 1);
    sts.flush_last = (CNT_W'(fi_r) + CNT_W'(1)) == count_r;
    sts.out_free   = out_free;
  end

  // Configuration targets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NODE_COUNT; n++) target_r[n] <= '0;
    end else if (cfg_we && (32'(cfg_index) < NODE_COUNT)) begin
      target_r[cfg_index[NODE_W-1:0]] <= cfg_data;
    end
  end

  // Node fills: one read-modify-write a cycle, cleared at end of round
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.round_clear) begin
      for (int n = 0; n < NODE_COUNT; n++) fill_r[n] <= '0;
    end else if (fill_we) begin
      fill_r[node_addr] <= sat_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      item_r <= in_data;
    end
  end

  // Buffer fill count and flush pointer
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.round_clear) begin
      count_r <= '0;
      fi_r    <= '0;
    end else begin
      if (cmd.spill_wr) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.emit_flush) begin
        fi_r <= fi_r + ADDR_W'(1);
      end
    end
  end

  assign spill_wr_data = '{tag: item_r.entry_tag, home: item_r.home_node,
                           bytes: item_r.entry_bytes};

  cbep_ram #(
    .WIDTH ($bits(spill_t)),
    .DEPTH (SPILL_DEPTH)
  ) u_spill_ram (
    .clk     (clk),
    .wr_en   (cmd.spill_wr),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (spill_wr_data),
    .rd_en   (cmd.flush_rd),
    .rd_addr (fi_r),
    .rd_data (spill_rd)
  );

  // Roomiest-node scan, one node per cycle; strict > keeps lowest index on ties
  always_ff @(posedge clk) begin
    if (cmd.flush_rd) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + NODE_W'(1);
      if (scan_idx_r == '0 || rem > best_rem_r) begin
        best_rem_r <= rem;
        best_idx_r <= scan_idx_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_item || cmd.emit_flush) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_item) begin
      out_data_r.result_tag  <= item_r.entry_tag;
      out_data_r.dest_node   <= item_r.home_node;
      out_data_r.moved       <= 1'b0;
      out_data_r.second_pass <= 1'b0;
      out_data_r.dropped     <= !sts.keep;
      out_data_r.last_result <= item_r.last_entry && sts.cnt_zero;
    end else if (cmd.emit_flush) begin
      out_data_r.result_tag  <= spill_rd.tag;
      out_data_r.dest_node   <= HOME_W'(best_idx_r);
      out_data_r.moved       <= HOME_W'(best_idx_r) != spill_rd.home;
      out_data_r.second_pass <= 1'b1;
      out_data_r.dropped     <= 1'b0;
      out_data_r.last_result <= sts.flush_last;
    end
  end

  assign out_data  = out_data_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/cbep_ctrl.sv -----
// Controller state machine: sequences first pass, buffering and overflow flush.
`default_nettype none

module cbep_ctrl
  import cbep_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd,
  output ctrl_state_t    state
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  ctrl_state_t after_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.fill_sel = FS_HOME;
    state_nxt  = state_r;
    in_stall   = state_r != ST_IDLE;

    // where to go once the entry's own result is loaded
    if (sts.last_entry && !sts.cnt_zero) begin
      after_emit = ST_FL_READ;
    end else begin
      after_emit = ST_IDLE;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL, ST_EMIT: begin
        if (sts.keep || sts.spill_full) begin
          if (sts.out_free) begin
            cmd.emit_item   = 1'b1;
            cmd.round_clear = sts.last_entry && sts.cnt_zero;
            state_nxt       = after_emit;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          cmd.spill_wr = 1'b1;
          state_nxt    = sts.last_entry ? ST_FL_READ : ST_IDLE;
        end
      end
      ST_FL_READ: begin
        cmd.flush_rd = 1'b1;
        state_nxt    = ST_FL_SCAN;
      end
      ST_FL_SCAN: begin
        cmd.fill_sel  = FS_SCAN;
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_FL_EMIT;
        end
      end
      ST_FL_EMIT: begin
        cmd.fill_sel = FS_BEST;
        if (sts.out_free) begin
          cmd.emit_flush = 1'b1;
          if (sts.flush_last) begin
            cmd.round_clear = 1'b1;
            state_nxt       = ST_IDLE;
          end else begin
            state_nxt = ST_FL_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

`default_nettype wire

// ----- rtl/capacity_balanced_entry_placer_core.sv -----
// Top level of the capacity balanced entry placer: controller plus datapath.
//
// Places cache entries onto NODE_COUNT nodes in rounds, worst-fit style. An
// entry stays on its home node when that node's fill is below its target and
// twice the remaining room covers the entry; otherwise it goes to an overflow
// buffer of SPILL_DEPTH entries, or is reported as dropped when the buffer is
// full. The entry flagged last_entry closes the round: every buffered entry,
// oldest first, is placed on the node with the greatest signed remaining room
// (target minus fill), ties to the lowest index, then fills and the buffer
// clear. Each entry passes through ST_EVAL before the next is taken (a kept
// or dropped one waits in ST_EMIT while out_stall holds the result register).
// Closing a round takes, per buffered entry, a buffer RAM read, the
// roomiest-node scan (one node per cycle through the single fill/target read
// port) and the emit. Targets are written through cfg_we/cfg_index/cfg_data;
// the user must do so only while the block is idle, which the block does not
// enforce. Indices at or above NODE_COUNT are ignored. The result register
// decouples the output, so a new entry is taken while a finished result waits.
`default_nettype none

module capacity_balanced_entry_placer_core
  import cbep_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int SPILL_DEPTH = SPILL_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // entry input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  // target configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FILL_W-1:0]    cfg_data
);

  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  ctrl_state_t state;

  // Sequencer: one entry at a time, flush loop at the end of a round.
  cbep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  // Node tables, overflow RAM, scan registers and result register.
  cbep_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .SPILL_DEPTH (SPILL_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // A result is only loaded when the result register is free or being taken.
  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_item || cmd.emit_flush) |-> sts.out_free)
    else $error("result register overwritten while holding a result");

  // The buffer is never written past its depth.
  a_no_spill_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.spill_wr |-> !sts.spill_full)
    else $error("overflow buffer written while full");

  // Closing a round leaves the buffer empty and the sequencer idle.
  a_round_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_clear |=> (sts.cnt_zero && state == ST_IDLE))
    else $error("round did not clear");

  // An entry transfer starts evaluation; entries are taken only while the sequencer is idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state == ST_EVAL))
    else $error("entry transfer did not start evaluation");

endmodule

`default_nettype wire

// ----- sim/tb_capacity_balanced_entry_placer_core.sv -----
// Testbench of the entry placer core: directed and random rounds against a placement predictor.
module tb_capacity_balanced_entry_placer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cbep_pkg::*;

  localparam int NODES          = NODE_COUNT_DEF;
  localparam int SPILL_CAP      = SPILL_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int SETTLE_CYCLES  = 40;    // quiet time before target writes and at the end
  localparam int RANDOM_ITEMS   = 120;
  localparam int PHASE_ITEMS    = 20;

  // Target layouts used by the random phases.
  typedef enum int {
    PLAN_SPREAD,  // small random targets, some zero
    PLAN_FULL,    // every target at its maximum
    PLAN_WIDE,    // full-range random targets
    PLAN_EVEN,    // equal targets, so the roomiest-node search sees ties
    PLAN_SINGLE,  // one node with room, the rest zero
    PLAN_MIXED    // a mix of zero, maximum and random
  } plan_t;

  // Tracks node fills, the overflow buffer and the results each transfer must cause.
  class placement_scoreboard_t;
    logic [FILL_W-1:0] target [NODES];
    logic [FILL_W-1:0] fill [NODES];
    spill_t            spill_q[$];
    out_item_t         expected_q[$];
    int                errors;

    function new();
      foreach (target[i]) begin
        target[i] = '0;
        fill[i]   = '0;
      end
      errors = 0;
    endfunction

    function void set_target(int idx, logic [FILL_W-1:0] value);
      if (idx < NODES) target[idx] = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Fill accumulators saturate at the all-ones value.
    function void add_fill(int n, logic [BYTES_W-1:0] bytes);
      logic [FILL_W:0] sum;
      sum     = {1'b0, fill[n]} + (FILL_W+1)'(bytes);
      fill[n] = sum[FILL_W] ? FILL_MAX : sum[FILL_W-1:0];
    endfunction

    function void note_entry(in_item_t e);
      out_item_t       r;
      spill_t          s;
      logic [FILL_W:0] room2;
      bit              fits;
      int              best;
      longint          best_rem;
      longint          rem;
      fits = 1'b0;
      if (int'(e.home_node) < NODES && fill[e.home_node] < target[e.home_node]) begin
        room2 = {target[e.home_node] - fill[e.home_node], 1'b0};
        fits  = room2 >= (FILL_W+1)'(e.entry_bytes);
      end
      if (fits) begin
        add_fill(e.home_node, e.entry_bytes);
        r = '{result_tag: e.entry_tag, dest_node: e.home_node, moved: 1'b0,
              second_pass: 1'b0, dropped: 1'b0,
              last_result: e.last_entry && spill_q.size() == 0};
        expected_q = {expected_q, r};
      end else if (spill_q.size() < SPILL_CAP) begin
        s = '{tag: e.entry_tag, home: e.home_node, bytes: e.entry_bytes};
        spill_q = {spill_q, s};
      end else begin
        r = '{result_tag: e.entry_tag, dest_node: e.home_node, moved: 1'b0,
              second_pass: 1'b0, dropped: 1'b1,
              last_result: e.last_entry && spill_q.size() == 0};
        expected_q = {expected_q, r};
      end
      if (e.last_entry) begin
        // oldest buffered entry first, each to the node with most signed room
        foreach (spill_q[k]) begin
          best     = 0;
          best_rem = longint'(target[0]) - longint'(fill[0]);
          for (int i = 1; i < NODES; i++) begin
            rem = longint'(target[i]) - longint'(fill[i]);
            if (rem > best_rem) begin
              best_rem = rem;
              best     = i;
            end
          end
          add_fill(best, spill_q[k].bytes);
          r.result_tag  = spill_q[k].tag;
          r.dest_node   = HOME_W'(best);
          r.moved       = best != int'(spill_q[k].home);
          r.second_pass = 1'b1;
          r.dropped     = 1'b0;
          r.last_result = k == spill_q.size() - 1;
          expected_q = {expected_q, r};
        end
        foreach (fill[i]) fill[i] = '0;
        spill_q.delete();
      end
    endfunction

    function void check_field(string field, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: tag %0h dest %0d",
               got.result_tag, got.dest_node);
        errors++;
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      check_field("result_tag", want.result_tag, got.result_tag);
      check_field("dest_node", want.dest_node, got.dest_node);
      check_field("moved", want.moved, got.moved);
      check_field("second_pass", want.second_pass, got.second_pass);
      check_field("dropped", want.dropped, got.dropped);
      check_field("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FILL_W-1:0]    cfg_data  = '0;

  placement_scoreboard_t sb = new();
  logic [FILL_W-1:0]    plan [NODES];   // targets for the next configuration phase
  logic [BYTES_W-1:0]   byte_span;      // usual upper bound of random entry sizes
  bit                   gaps_on = 1'b1; // random idling on both channels
  int                   quiet_cycles = 0;

  capacity_balanced_entry_placer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver back-pressure, changed at the falling edge only.
  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 23);
  end

  // Everything is sampled at the rising edge: target writes update the
  // predictor, accepted entries queue their expected results, accepted results
  // are checked. The watchdog counts edges with no transfer on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_target(int'(cfg_index), cfg_data);
      if (in_valid && !in_stall) sb.note_entry(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  function automatic logic [FILL_W-1:0] rand_fill();
    return FILL_W'({$urandom_range(0, 255), $urandom});
  endfunction

  // Sizes: mostly within the phase's span, with zero, all-ones and full range mixed in.
  function automatic logic [BYTES_W-1:0] pick_bytes();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return $urandom_range(0, byte_span);
    endcase
  endfunction

  function automatic void set_plan(plan_t p);
    int lone;
    lone = $urandom_range(0, NODES - 1);
    foreach (plan[i]) begin
      case (p)
        PLAN_SPREAD: plan[i] = ($urandom_range(0, 4) == 0) ? '0 :
                               FILL_W'($urandom_range(0, 1 << 24));
        PLAN_FULL:   plan[i] = FILL_MAX;
        PLAN_WIDE:   plan[i] = rand_fill();
        PLAN_EVEN:   plan[i] = FILL_W'(1) << 22;
        PLAN_SINGLE: plan[i] = (i == lone) ? FILL_W'(1) << 30 : '0;
        default: begin
          case ($urandom_range(0, 3))
            0:       plan[i] = '0;
            1:       plan[i] = FILL_MAX;
            2:       plan[i] = FILL_W'($urandom_range(0, 1 << 26));
            default: plan[i] = rand_fill();
          endcase
        end
      endcase
    end
    case (p)
      PLAN_SPREAD: byte_span = 32'h0080_0000;
      PLAN_EVEN:   byte_span = 32'h0010_0000;
      PLAN_SINGLE: byte_span = 32'h1000_0000;
      PLAN_MIXED:  byte_span = 32'h0100_0000;
      default:     byte_span = '1;
    endcase
  endfunction

  // One entry transfer: optional idle cycles, then hold the entry until taken.
  // Returns right after the accepting edge so back-to-back entries keep valid high.
  task automatic send_entry(input logic [TAG_W-1:0] tag, input int home,
                            input logic [BYTES_W-1:0] bytes, input bit last);
    in_item_t e;
    e = '{entry_tag: tag, home_node: HOME_W'(home), entry_bytes: bytes, last_entry: last};
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= e;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender pauses until every expected result has been taken, then idles a while.
  task automatic drain(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Writes the whole target plan while the block is idle; the indices past the
  // node list get junk, which the block must ignore.
  task automatic load_targets();
    drain(SETTLE_CYCLES);
    for (int i = 0; i < 2 ** CFG_IDX_W; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= (i < NODES) ? plan[i] : rand_fill();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A round is mostly short; now and then long enough to overflow the buffer.
  task automatic random_round(output int count);
    int len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) drain(0);
      send_entry(TAG_W'($urandom), $urandom_range(0, NODES - 1), pick_bytes(), i == len - 1);
    end
    count = len;
  endtask

  initial begin
    int    phase_items;
    int    done_items;
    int    n;
    plan_t p;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed round: zero, unit, exact and maximal targets.
    plan = '{40'd0, FILL_MAX, 40'd1, 40'd1000, 40'h01_0000_0000,
             40'd5000, 40'd123456, 40'h80_0000_0000};
    byte_span = '1;
    load_targets();
    send_entry(16'h0000, 1, 32'hFFFF_FFFF, 1'b0);  // largest entry fits a maximal target
    send_entry(16'hFFFF, 0, 32'h0, 1'b0);          // zero target never keeps, even size zero
    send_entry(16'h0002, 2, 32'd2, 1'b0);          // size exactly twice the room
    send_entry(16'h0003, 2, 32'd0, 1'b0);          // fill already over target
    send_entry(16'h0004, 3, 32'd2000, 1'b0);       // exact fit on a larger target
    send_entry(16'h0005, 6, 32'd246913, 1'b0);     // one byte past twice the room
    send_entry(16'h0006, 4, 32'hFFFF_FFFF, 1'b0);
    send_entry(16'hA5A5, 7, 32'h8000_0000, 1'b1);  // kept last entry, buffer flushes after
    send_entry(16'h5A5A, 5, 32'd10, 1'b1);         // lone kept entry closes its round
    send_entry(16'h1234, 0, 32'd7, 1'b1);          // lone buffered entry closes its round

    // All targets zero: everything spills, the buffer fills, the rest drop,
    // the last entry among them. The flush then sees ties and negative room.
    foreach (plan[i]) plan[i] = '0;
    load_targets();
    for (int i = 0; i < SPILL_CAP + 2; i++) begin
      send_entry(TAG_W'($urandom), $urandom_range(0, NODES - 1),
                 (i % 2 == 1) ? '1 : BYTES_W'($urandom), i == SPILL_CAP + 1);
    end

    // Saturation: 256 maximal entries bring node 0 within 255 bytes of the
    // maximum fill; a 510-byte entry still fits and pushes the sum past it.
    foreach (plan[i]) plan[i] = FILL_MAX;
    load_targets();
    for (int i = 0; i < 256; i++) send_entry(TAG_W'($urandom), 0, '1, 1'b0);
    send_entry(TAG_W'($urandom), 0, 32'd510, 1'b0);
    send_entry(TAG_W'($urandom), 0, 32'd0, 1'b1);

    // Random phases, one per target layout; the tie phase runs with no idling.
    done_items = 0;
    for (int phase = 0; done_items < RANDOM_ITEMS; phase++) begin
      p = plan_t'(phase % 6);
      set_plan(p);
      load_targets();
      gaps_on     = p != PLAN_EVEN;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        random_round(n);
        phase_items += n;
      end
      done_items += phase_items;
    end
    gaps_on = 1'b1;

    drain(SETTLE_CYCLES);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cbep_pkg.sv
rtl/cbep_ram.sv
rtl/cbep_datapath.sv
rtl/cbep_ctrl.sv
rtl/capacity_balanced_entry_placer_core.sv
sim/tb_capacity_balanced_entry_placer_core.sv
